// ===== hw/rtl/sct_pkg.sv =====
package sct_pkg;

   localparam int TERMS     = 7;
   localparam int MAX_TERMS = 9;
   // multiplier slots: angle*pi, x*x, horner steps, final *x
   localparam int SLOTS     = TERMS + 2;
   localparam int MUL_DEPTH = 3;
   localparam int STAGES    = MUL_DEPTH * SLOTS;

   localparam logic signed [63:0] PI_Q60   = 64'sh3243F6A8885A308D;
   localparam logic        [63:0] MAG_LIM  = 64'h4000000000000000;
   localparam logic signed [31:0] ONE_Q30  = 32'sh40000000;

   localparam logic signed [63:0] SIN_COEF [MAX_TERMS] = '{
      64'sd1152921504606846976, -64'sd192153584101141163, 64'sd9607679205057058,
      -64'sd228754266787073, 64'sd3177142594265, -64'sd28883114493,
      64'sd185148170, -64'sd881658, 64'sd3241
   };

   localparam logic signed [63:0] COS_COEF [MAX_TERMS] = '{
      64'sd1152921504606846976, -64'sd576460752303423488, 64'sd48038396025285291,
      -64'sd1601279867509510, 64'sd28594283348384, -64'sd317714259426,
      64'sd2406926208, -64'sd13224869, 64'sd55104
   };

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] pc;
      logic               last;
   } side_type;

   // round q60 to q30, ties away from zero, saturate to +-1
   function automatic logic signed [31:0] to_q30(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] rnd;
      logic [33:0] q;
      logic [31:0] m32;
      mag = v[63] ? (64'd0 - v) : v;
      rnd = mag + 64'h20000000;
      q   = rnd[63:30];
      m32 = (q > 34'h040000000) ? ONE_Q30 : q[31:0];
      return v[63] ? -$signed(m32) : $signed(m32);
   endfunction

endpackage

// ===== hw/rtl/sct_mul.sv =====
module sct_mul (
   input  logic               clock,
   input  logic [2:0]         en,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   input  logic signed [63:0] addend,
   output logic signed [63:0] p
);
   import sct_pkg::*;

   logic [63:0]  ua;
   logic [63:0]  ub;
   logic [63:0]  lo_ff, m1_ff, m2_ff, hi_ff;
   logic         neg1_ff, neg2_ff;
   logic [127:0] sum_in, sum_ff;
   logic [69:0]  q;
   logic [63:0]  mag;
   logic signed [63:0] p_in, p_ff;

   assign ua = a[63] ? (64'd0 - a) : a;
   assign ub = b[63] ? (64'd0 - b) : b;

   // stage 1: four 32x32 partial products
   always_ff @(posedge clock) begin
      if (en[0]) begin
         lo_ff   <= {32'd0, ua[31:0]}  * {32'd0, ub[31:0]};
         m1_ff   <= {32'd0, ua[63:32]} * {32'd0, ub[31:0]};
         m2_ff   <= {32'd0, ua[31:0]}  * {32'd0, ub[63:32]};
         hi_ff   <= {32'd0, ua[63:32]} * {32'd0, ub[63:32]};
         neg1_ff <= a[63] ^ b[63];
      end
   end

   // stage 2: combine, add rounding half of q58
   assign sum_in = {64'd0, lo_ff} + {32'd0, m1_ff, 32'd0} + {32'd0, m2_ff, 32'd0}
                 + {hi_ff, 64'd0} + (128'd1 << 57);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sum_ff  <= sum_in;
         neg2_ff <= neg1_ff;
      end
   end

   // stage 3: clamp, restore sign, add coefficient
   assign q    = sum_ff[127:58];
   assign mag  = (q > {6'd0, MAG_LIM}) ? MAG_LIM : q[63:0];
   assign p_in = (neg2_ff ? -$signed(mag) : $signed(mag)) + addend;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;
endmodule

// ===== hw/rtl/sincospi_taylor.sv =====
// sincospi_taylor: sin(pi*t) and cos(pi*t) of a signed q8.24 angle t
// in units of pi, results signed q1.30 saturated to +-1.
// input channel req_*: angle and a last marker, transfer on valid & ready
// output channel rsp_*: sine, cosine and the copied last marker
// the angle wraps to [-1,1) by keeping its low 25 bits, is scaled by pi,
// then both seven-term taylor series run by horner's rule in x*x
// each 64-bit product uses a three-stage multiplier (partials, sum,
// round/clamp/add); there are TERMS+2 multiplier slots in a chain
// throughput: one transfer per cycle while the receiver keeps rsp_ready high, set by the fully pipelined slots
// every stage carries a valid bit and stalls only when its successor is
// full and stalled, so bubbles close up while the receiver holds off
// when rsp_ready is low the result holds in the output register and the
// pipeline keeps filling; req_ready drops only once every stage is full
// reset clears all valid bits; data registers are not reset
module sincospi_taylor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_angle_turns,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_sine,
   output logic [31:0] rsp_cosine,
   output logic        rsp_last_out
);
   import sct_pkg::*;

   logic [STAGES:0]     en;
   logic [STAGES-1:0]   valid_ff;
   side_type            side_ff [STAGES];
   side_type            side_in [STAGES];
   logic signed [63:0]  sin_res [SLOTS];
   logic signed [63:0]  cos_res [TERMS-1];
   logic                rsp_valid_ff;
   logic signed [31:0]  sine_ff, cosine_ff;
   logic                last_ff;

   // stage enables: a stage loads when empty or when its successor moves
   assign en[STAGES] = !rsp_valid_ff || rsp_ready;
   assign req_ready  = en[0];

   genvar s, m;
   generate
      for (s = 0; s < STAGES; s++) begin : g_stage
         assign en[s] = !valid_ff[s] || en[s+1];

         always_comb begin
            if (s == 0) begin
               side_in[s]      = '0;
               side_in[s].last = req_last_in;
            end else begin
               side_in[s] = side_ff[(s == 0) ? 0 : s-1];
               // x leaves slot 0, y leaves slot 1, cosine leaves the last horner slot
               if (s == MUL_DEPTH)              side_in[s].x  = sin_res[0];
               if (s == 2*MUL_DEPTH)            side_in[s].y  = sin_res[1];
               if (s == MUL_DEPTH*(TERMS+1))    side_in[s].pc = cos_res[TERMS-2];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (en[s]) begin
               valid_ff[s] <= (s == 0) ? req_valid : valid_ff[(s == 0) ? 0 : s-1];
            end
         end

         always_ff @(posedge clock) begin
            if (en[s]) begin
               side_ff[s] <= side_in[s];
            end
         end
      end

      for (m = 0; m < SLOTS; m++) begin : g_slot
         logic signed [63:0] a_sin, b_sin, c_sin;

         if (m == 0) begin : g_pi
            // wrapped angle as q1.24, moved up 32 bits so every product shifts by 58
            assign a_sin = {{7{req_angle_turns[24]}}, req_angle_turns[24:0], 32'd0};
            assign b_sin = PI_Q60;
            assign c_sin = '0;
         end else if (m == 1) begin : g_sq
            assign a_sin = sin_res[0];
            assign b_sin = sin_res[0];
            assign c_sin = '0;
         end else if (m <= TERMS) begin : g_horner
            logic signed [63:0] a_cos, b_y;
            assign b_y   = (m == 2) ? sin_res[1] : side_ff[MUL_DEPTH*m-1].y;
            assign a_sin = (m == 2) ? SIN_COEF[TERMS-1] : sin_res[(m == 2) ? 0 : m-1];
            assign a_cos = (m == 2) ? COS_COEF[TERMS-1] : cos_res[(m == 2) ? 0 : m-3];
            assign b_sin = b_y;
            assign c_sin = SIN_COEF[TERMS-m];

            sct_mul u_cos (
               .clock  (clock),
               .en     (en[MUL_DEPTH*m +: MUL_DEPTH]),
               .a      (a_cos),
               .b      (b_y),
               .addend (COS_COEF[TERMS-m]),
               .p      (cos_res[m-2])
            );
         end else begin : g_fin
            // sine series times x
            assign a_sin = sin_res[m-1];
            assign b_sin = side_ff[MUL_DEPTH*m-1].x;
            assign c_sin = '0;
         end

         sct_mul u_sin (
            .clock  (clock),
            .en     (en[MUL_DEPTH*m +: MUL_DEPTH]),
            .a      (a_sin),
            .b      (b_sin),
            .addend (c_sin),
            .p      (sin_res[m])
         );
      end
   endgenerate

   // output register: final rounding to q1.30
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en[STAGES]) begin
         rsp_valid_ff <= valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[STAGES]) begin
         sine_ff   <= to_q30(sin_res[SLOTS-1]);
         cosine_ff <= to_q30(side_ff[STAGES-1].pc);
         last_ff   <= side_ff[STAGES-1].last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sine     = sine_ff;
   assign rsp_cosine   = cosine_ff;
   assign rsp_last_out = last_ff;
endmodule

// ===== dv/testbench.sv =====
module testbench;
   import sct_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_angle_turns;
   logic        req_last_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_sine;
   logic [31:0] rsp_cosine;
   logic        rsp_last_out;

   sincospi_taylor dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_angle_turns (req_angle_turns),
      .req_last_in     (req_last_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sine        (rsp_sine),
      .rsp_cosine      (rsp_cosine),
      .rsp_last_out    (rsp_last_out)
   );

   // one expected sine/cosine pair
   typedef struct {
      logic [31:0] sine;
      logic [31:0] cosine;
      logic        last;
      logic [31:0] angle;
   } trig_result_type;

   // predicts sin(pi*t), cos(pi*t) and checks results in order
   class trig_scoreboard_type;
      trig_result_type pending[$];
      logic signed [63:0] sin_taylor[MAX_TERMS];
      logic signed [63:0] cos_taylor[MAX_TERMS];
      int errors;
      int matched;

      function new();
         logic [63:0] fact;
         fact = 64'd1;
         // coefficient k is +-1/(2k)! or +-1/(2k+1)!, held as q60
         for (int k = 0; k < MAX_TERMS; k++) begin
            if (k > 0) fact = fact * (2 * k - 1) * (2 * k);
            cos_taylor[k] = ((64'd1 << 60) + fact / 2) / fact;
            sin_taylor[k] = ((64'd1 << 60) + fact * (2 * k + 1) / 2) / (fact * (2 * k + 1));
            if (k % 2 == 1) begin
               cos_taylor[k] = -cos_taylor[k];
               sin_taylor[k] = -sin_taylor[k];
            end
         end
         errors  = 0;
         matched = 0;
      endfunction

      // exact product, rounded half away from zero, clamped to 2^62
      function automatic logic signed [63:0] scaled_product(
            input logic signed [63:0] a, input logic signed [63:0] b, input int sh);
         logic         neg;
         logic [63:0]  ua;
         logic [63:0]  ub;
         logic [63:0]  mag;
         logic [127:0] prod;
         neg  = a[63] ^ b[63];
         ua   = a[63] ? 64'd0 - a : a;
         ub   = b[63] ? 64'd0 - b : b;
         prod = {64'd0, ua} * {64'd0, ub};
         prod = (prod + (128'd1 << (sh - 1))) >> sh;
         mag  = (prod > 128'h4000000000000000) ? 64'h4000000000000000 : prod[63:0];
         return neg ? -$signed(mag) : $signed(mag);
      endfunction

      function automatic logic signed [63:0] series(input logic is_sine,
            input logic signed [63:0] y);
         logic signed [63:0] p;
         p = is_sine ? sin_taylor[TERMS-1] : cos_taylor[TERMS-1];
         for (int k = TERMS - 2; k >= 0; k--)
            p = scaled_product(p, y, 58) + (is_sine ? sin_taylor[k] : cos_taylor[k]);
         return p;
      endfunction

      function automatic logic [31:0] q30_sat(input logic signed [63:0] v);
         logic signed [63:0] r;
         r = scaled_product(v, 64'sd1, 30);
         if (r > 64'sd1073741824) r = 64'sd1073741824;
         if (r < -64'sd1073741824) r = -64'sd1073741824;
         return r[31:0];
      endfunction

      function void note_angle(input logic [31:0] angle, input logic last);
         logic signed [63:0] t;
         logic signed [63:0] x;
         logic signed [63:0] y;
         trig_result_type e;
         // wrap to [-1,1): low 25 bits as signed q1.24
         t = {{39{angle[24]}}, angle[24:0]};
         x = scaled_product(t, PI_Q60, 26);
         y = scaled_product(x, x, 58);
         e.sine   = q30_sat(scaled_product(series(1'b1, y), x, 58));
         e.cosine = q30_sat(series(1'b0, y));
         e.last   = last;
         e.angle  = angle;
         pending.push_back(e);
      endfunction

      task report(input string what, input logic [31:0] angle,
            input logic [31:0] got, input logic [31:0] want);
         errors++;
         $display("mismatch %s angle=%h got=%h want=%h", what, angle, got, want);
      endtask

      task check_result(input logic [31:0] s, input logic [31:0] c, input logic l);
         trig_result_type e;
         if (pending.size() == 0) begin
            report("unexpected result", 32'h0, s, 32'h0);
            return;
         end
         e = pending.pop_front();
         if (s !== e.sine) report("sine", e.angle, s, e.sine);
         if (c !== e.cosine) report("cosine", e.angle, c, e.cosine);
         if (l !== e.last) report("last", e.angle, {31'd0, l}, {31'd0, e.last});
         matched++;
      endtask
   endclass

   trig_scoreboard_type sb;
   int  sent;
   int  stall_cycles = 0;
   int  idle_cycles  = 0;
   bit  squeeze;        // sender asks the receiver for one long hold-off
   bit  squeeze_done;

   // 8 unit clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one transfer on the request side, driven at the falling edge
   task send_angle(input logic [31:0] angle, input logic last);
      req_valid       <= 1'b1;
      req_angle_turns <= angle;
      req_last_in     <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_angle(angle, last);
      sent++;
      @(negedge clock);
   endtask

   // mostly back to back, some short gaps, rarely a long one
   task sender_gap(input bit burst);
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (burst || r < 60) return;
      n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // random angle: full range, near turn boundaries, or small
   function automatic logic [31:0] pick_angle();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom();
      if (r < 8) return {8'($urandom_range(0, 255)), 24'h0} + 32'($urandom_range(0, 8)) - 32'd4;
      return {{12{1'b0}}, 20'($urandom())} ^ ({32{$urandom_range(0, 1) == 1}});
   endfunction

   // request side
   initial begin
      logic [31:0] directed[$];
      bit burst;
      sb              = new();
      sent            = 0;
      squeeze         = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_angle_turns = 32'h0;
      req_last_in     = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero, quarter points, the wrap point, odd turns and field extremes
      directed = '{32'h00000000, 32'h00400000, 32'h00800000, 32'h00C00000,
                   32'h01000000, 32'hFF000000, 32'h03000000, 32'h7F000000,
                   32'h81000000, 32'hFF800000, 32'hFFC00000, 32'h7FFFFFFF,
                   32'h80000000, 32'hFFFFFFFF, 32'h00000001, 32'h00FFFFFF,
                   32'h01FFFFFF, 32'h00200000, 32'h00555555, 32'hAAAAAAAA,
                   32'h55555555, 32'h02000000};
      foreach (directed[i]) begin
         send_angle(directed[i], 1'(i % 2));
         sender_gap(1'b0);
      end

      for (int i = 0; i < 1630; i++) begin
         if (i % 200 == 0) burst = ($urandom_range(0, 2) == 0);
         if (i == 400) squeeze = 1'b1;
         send_angle(pick_angle(), $urandom_range(0, 7) == 0);
         sender_gap(burst);
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("sent %0d angles, %0d results checked, request side stalled %0d cycles",
               sent, sb.matched, stall_cycles);
      $display("covered wrap points, odd turns, full-range and near-boundary angles");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // response side: random back-pressure plus one long hold-off
   initial begin
      int r;
      int n;
      rsp_ready    = 1'b0;
      squeeze_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (squeeze && !squeeze_done) begin
            squeeze_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 70) begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 30);
         end else begin
            rsp_ready <= 1'b0;
            n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         end
         repeat (n) @(negedge clock);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_sine, rsp_cosine, rsp_last_out);
   end

   // watchdog on cycles without any transfer, and stall count
   always @(posedge clock) begin
      if (!reset && req_valid && !req_ready) stall_cycles++;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= 5000) begin
         $display("timeout with %0d results outstanding", sb.pending.size());
         $display("FAILURE");
         $finish;
      end
   end

endmodule
